// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port-level checker in dmcts_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/dmcts_pkg.sv =====
// types and constants of the cache tag store
package dmcts_pkg;

  localparam int ADDR_BITS_DEF   = 32;
  localparam int INDEX_BITS_DEF  = 8;
  localparam int OFFSET_BITS_DEF = 5;

  // fixed widths of the beat fields
  localparam int FIELD_ADDR_W = 32;
  localparam int EVICT_W      = 2;

  typedef enum logic [EVICT_W-1:0] {
    EVICT_EMPTY = 2'd0,
    EVICT_CLEAN = 2'd1,
    EVICT_DIRTY = 2'd2
  } evict_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CMP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;  // clear one line, advance sweep counter
    logic load;      // latch beat, read its line
    logic update;    // compare, write line back, emit result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // sweep counter at the last line
  } dp_status_t;

endpackage

// ===== hw/rtl/direct_mapped_cache_tag_store.sv =====
// top level of the direct-mapped write-back cache tag store
//
//   channel  ports                                        handshake
//   ------   -------------------------------------------  ---------------------
//   in       in_command, in_address                       start && !busy
//   out      out_hit, out_eviction, out_victim_address    out_valid, one cycle
//
// - each beat: the line is read when the beat is accepted; in the compare
//   state it is compared, written back and the result registered
// - the result shows on out_* the cycle after that, for one cycle only;
//   busy is already low then, so the next beat may be accepted alongside it
// - after reset a clearing pass walks all 2**INDEX_BITS lines (256 by default)
//   of the line memory one line per cycle, with busy high
// - the receiver cannot stall; nothing is held back on the result side
//
// the line memory holds valid, dirty and tag per line; a miss installs the
// new tag (write-allocate), a write marks the line dirty
module direct_mapped_cache_tag_store #(
  parameter int ADDR_BITS   = dmcts_pkg::ADDR_BITS_DEF,
  parameter int INDEX_BITS  = dmcts_pkg::INDEX_BITS_DEF,
  parameter int OFFSET_BITS = dmcts_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beat
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_command,
  input  logic [dmcts_pkg::FIELD_ADDR_W-1:0]  in_address,
  // result beat
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [dmcts_pkg::EVICT_W-1:0]       out_eviction,
  output logic [dmcts_pkg::FIELD_ADDR_W-1:0]  out_victim_address
);

  // command and status between controller and datapath
  dmcts_pkg::ctrl_cmd_t  cmd;
  dmcts_pkg::dp_status_t status;

  // sequencing: clear sweep, idle, compare-and-write
  dmcts_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // line memory, tag compare, victim rebuild and result registers
  dmcts_dp #(
    .ADDR_BITS   (ADDR_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_command         (in_command),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_eviction       (out_eviction),
    .out_victim_address (out_victim_address)
  );

endmodule

// ===== hw/rtl/dmcts_ctrl.sv =====
// controller state machine of the cache tag store
module dmcts_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  dmcts_pkg::dp_status_t  status,
  output logic                   busy,
  output dmcts_pkg::ctrl_cmd_t   cmd
);

  dmcts_pkg::state_t state_r;
  dmcts_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmcts_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmcts_pkg::ST_CLEAR: begin
        if (status.clr_last) state_nxt = dmcts_pkg::ST_IDLE;
      end
      dmcts_pkg::ST_IDLE: begin
        if (start) state_nxt = dmcts_pkg::ST_CMP;
      end
      dmcts_pkg::ST_CMP: begin
        state_nxt = dmcts_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dmcts_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    cmd.clr_step = 1'b0;
    cmd.load     = 1'b0;
    cmd.update   = 1'b0;
    case (state_r)
      dmcts_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      dmcts_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      dmcts_pkg::ST_CMP: begin
        cmd.update = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dmcts_dp.sv =====
// datapath of the cache tag store: line memory, compare and result registers
module dmcts_dp #(
  parameter int ADDR_BITS   = dmcts_pkg::ADDR_BITS_DEF,
  parameter int INDEX_BITS  = dmcts_pkg::INDEX_BITS_DEF,
  parameter int OFFSET_BITS = dmcts_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dmcts_pkg::ctrl_cmd_t                cmd,
  output dmcts_pkg::dp_status_t               status,
  input  logic                                in_command,
  input  logic [dmcts_pkg::FIELD_ADDR_W-1:0]  in_address,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [dmcts_pkg::EVICT_W-1:0]       out_eviction,
  output logic [dmcts_pkg::FIELD_ADDR_W-1:0]  out_victim_address
);

  localparam int TAG_BITS  = ADDR_BITS - INDEX_BITS - OFFSET_BITS;
  localparam int NUM_LINES = 1 << INDEX_BITS;
  localparam int ENTRY_W   = TAG_BITS + 2;
  localparam int VLD_POS   = TAG_BITS + 1;
  localparam int DRT_POS   = TAG_BITS;

  // entry layout: valid, dirty, tag
  logic [ENTRY_W-1:0] mem [NUM_LINES];

  logic [INDEX_BITS-1:0] clr_cnt_r;
  logic [ENTRY_W-1:0]    rd_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [TAG_BITS-1:0]   tag_r;
  logic                  cmd_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  dmcts_pkg::evict_t     out_evict_r;
  logic [dmcts_pkg::FIELD_ADDR_W-1:0] out_victim_r;

  logic [63:0]           addr64;
  logic [ADDR_BITS-1:0]  addr_w;
  logic [INDEX_BITS-1:0] in_idx;
  logic [TAG_BITS-1:0]   in_tag;

  logic                  rd_valid;
  logic                  rd_dirty;
  logic [TAG_BITS-1:0]   rd_tag;
  logic                  hit;
  logic [ENTRY_W-1:0]    wdata;
  logic [ADDR_BITS-1:0]  victim_w;
  logic [63:0]           victim64;
  dmcts_pkg::evict_t     evict_nxt;
  logic [dmcts_pkg::FIELD_ADDR_W-1:0] victim_nxt;

  // bits above ADDR_BITS are dropped
  assign addr64 = {32'd0, in_address};
  assign addr_w = addr64[ADDR_BITS-1:0];
  assign in_idx = addr_w[OFFSET_BITS +: INDEX_BITS];
  assign in_tag = addr_w[ADDR_BITS-1 -: TAG_BITS];

  assign rd_valid = rd_r[VLD_POS];
  assign rd_dirty = rd_r[DRT_POS];
  assign rd_tag   = rd_r[TAG_BITS-1:0];
  assign hit      = rd_valid && (rd_tag == tag_r);

  // hit keeps its tag and sets dirty on write; miss installs the new tag
  assign wdata = {1'b1, hit ? (rd_dirty | cmd_r) : cmd_r, tag_r};

  assign victim_w = {rd_tag, idx_r, {OFFSET_BITS{1'b0}}};
  assign victim64 = 64'(victim_w);

  always_comb begin
    evict_nxt  = dmcts_pkg::EVICT_EMPTY;
    victim_nxt = '0;
    if (!hit && rd_valid) begin
      evict_nxt  = rd_dirty ? dmcts_pkg::EVICT_DIRTY : dmcts_pkg::EVICT_CLEAN;
      victim_nxt = victim64[dmcts_pkg::FIELD_ADDR_W-1:0];
    end
  end

  assign status.clr_last = (clr_cnt_r == {INDEX_BITS{1'b1}});

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.update) begin
      mem[idx_r] <= wdata;
    end
    if (cmd.load) begin
      rd_r <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= in_idx;
      tag_r <= in_tag;
      cmd_r <= in_command;
    end
    if (cmd.update) begin
      out_hit_r    <= hit;
      out_evict_r  <= evict_nxt;
      out_victim_r <= victim_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_eviction       = out_evict_r;
  assign out_victim_address = out_victim_r;

endmodule

// ===== hw/rtl/dmcts_checker.sv =====
// port-level checker of the cache tag store and its bind
`include "assert_macros.svh"

module dmcts_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                out_valid,
  input  logic                                out_hit,
  input  logic [dmcts_pkg::EVICT_W-1:0]       out_eviction,
  input  logic [dmcts_pkg::FIELD_ADDR_W-1:0]  out_victim_address
);

  logic acc;

  assign acc = start && !busy;

  // every accepted beat is followed by its result strobe on out_valid
  `ASSERT_IMPL(a_result_latency, acc, ##2 out_valid)

  // out_valid always drops again straight after a result strobe
  `ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)

  // a hit evicts nothing
  `ASSERT_IMPL(a_hit_no_evict, out_valid && out_hit,
    out_eviction == dmcts_pkg::EVICT_EMPTY && out_victim_address == '0)

  // an empty line reports no victim address
  `ASSERT_IMPL(a_empty_zero_victim, out_valid && out_eviction == dmcts_pkg::EVICT_EMPTY,
    out_victim_address == '0)

endmodule

bind direct_mapped_cache_tag_store dmcts_checker u_dmcts_checker (.*);

// ===== bench/tb_direct_mapped_cache_tag_store.sv =====
// self-checking testbench of the direct-mapped cache tag store
`timescale 1ns / 1ps

module tb_direct_mapped_cache_tag_store;

  // address split at the default parameters: tag | index | offset
  localparam int INDEX_W   = dmcts_pkg::INDEX_BITS_DEF;
  localparam int OFFSET_W  = dmcts_pkg::OFFSET_BITS_DEF;
  localparam int TAG_W     = dmcts_pkg::ADDR_BITS_DEF - dmcts_pkg::INDEX_BITS_DEF
                             - dmcts_pkg::OFFSET_BITS_DEF;
  localparam int NUM_LINES = 1 << INDEX_W;
  localparam int ADDR_W    = dmcts_pkg::FIELD_ADDR_W;
  localparam int EV_W      = dmcts_pkg::EVICT_W;

  // access kinds on in_command
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam int N_RANDOM  = 1350;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic              command;
    logic [ADDR_W-1:0] address;
  } cache_access_t;

  typedef struct {
    logic               hit;
    dmcts_pkg::evict_t  eviction;
    logic [ADDR_W-1:0]  victim;
  } lookup_result_t;

  // mirror of the line memory plus the queue of lookups still owed by the block
  class lookup_scoreboard;
    bit [TAG_W-1:0] line_tag [NUM_LINES];
    bit             line_valid [NUM_LINES];
    bit             line_dirty [NUM_LINES];
    lookup_result_t expected_lookups[$];
    int             mismatches;

    function new();
      mismatches = 0;
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_tag[i]   = '0;
      end
    endfunction

    // accepted access beat: work out the lookup outcome and update the lines
    function void note_access(logic command, logic [ADDR_W-1:0] address);
      lookup_result_t r;
      logic [INDEX_W-1:0] idx;
      logic [TAG_W-1:0]   tag;
      idx = address[OFFSET_W +: INDEX_W];
      tag = address[ADDR_W-1 -: TAG_W];
      r.hit      = 1'b0;
      r.eviction = dmcts_pkg::EVICT_EMPTY;
      r.victim   = '0;
      if (line_valid[idx] && line_tag[idx] == tag) begin
        r.hit = 1'b1;
        if (command == CMD_WRITE) line_dirty[idx] = 1'b1;
      end else begin
        if (line_valid[idx]) begin
          r.eviction = line_dirty[idx] ? dmcts_pkg::EVICT_DIRTY : dmcts_pkg::EVICT_CLEAN;
          r.victim   = {line_tag[idx], idx, {OFFSET_W{1'b0}}};
        end
        // write-allocate fill, dirty only for a write
        line_tag[idx]   = tag;
        line_valid[idx] = 1'b1;
        line_dirty[idx] = (command == CMD_WRITE);
      end
      expected_lookups.push_back(r);
    endfunction

    // result beat from the block, compared with the oldest lookup owed
    function void check_lookup(logic hit, logic [EV_W-1:0] eviction,
                               logic [ADDR_W-1:0] victim);
      lookup_result_t e;
      if (expected_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("[%0t] unexpected result beat: hit=%0b eviction=%0d victim=%h",
                   $time, hit, eviction, victim);
        return;
      end
      e = expected_lookups.pop_front();
      if (hit !== e.hit || eviction !== e.eviction || victim !== e.victim) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display({"[%0t] lookup mismatch: exp hit=%0b eviction=%0d victim=%h, ",
                    "got hit=%0b eviction=%0d victim=%h"},
                   $time, e.hit, e.eviction, e.victim, hit, eviction, victim);
      end
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_command;
  logic [ADDR_W-1:0] in_address;
  logic              out_valid;
  logic              out_hit;
  logic [EV_W-1:0]   out_eviction;
  logic [ADDR_W-1:0] out_victim_address;

  direct_mapped_cache_tag_store uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_eviction      (out_eviction),
    .out_victim_address(out_victim_address)
  );

  lookup_scoreboard sb;
  cache_access_t    access_q[$];
  int               n_directed;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling on the simulated time
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] line_address(
      logic [TAG_W-1:0] tag, logic [INDEX_W-1:0] idx, logic [OFFSET_W-1:0] off);
    return {tag, idx, off};
  endfunction

  function automatic void push_access(logic command, logic [ADDR_W-1:0] address);
    cache_access_t a;
    a.command = command;
    a.address = address;
    access_q.push_back(a);
  endfunction

  // hand-picked sequence: empty, clean and dirty victims, hits of both kinds,
  // all-zero and all-one addresses, extreme tags and offsets
  task automatic build_directed();
    push_access(CMD_READ,  32'h0000_0000);                    // empty line miss
    push_access(CMD_READ,  line_address('0, '0, '1));         // hit, other offset
    push_access(CMD_WRITE, line_address('0, '0, 5'h04));      // write hit marks dirty
    push_access(CMD_READ,  line_address(19'd1, '0, '0));      // dirty victim at 0
    push_access(CMD_READ,  line_address(19'd1, '0, 5'h10));   // read hit
    push_access(CMD_READ,  line_address(19'd2, '0, '0));      // clean victim
    push_access(CMD_WRITE, 32'hFFFF_FFFF);                    // write miss, empty line
    push_access(CMD_READ,  32'hFFFF_FFE0);                    // hit on dirty line
    push_access(CMD_READ,  line_address('0, '1, '0));         // dirty victim, all-one tag
    push_access(CMD_WRITE, line_address('0, '1, '1));         // write hit on clean line
    push_access(CMD_WRITE, line_address('1, '1, 5'h0A));      // write miss, dirty victim
    push_access(CMD_WRITE, line_address(19'h55555, 8'hAA, 5'h15));
    push_access(CMD_WRITE, line_address(19'h55555, 8'hAA, 5'h0A)); // hit, stays dirty
    push_access(CMD_READ,  line_address(19'h2AAAA, 8'hAA, 5'h0A)); // dirty victim
    push_access(CMD_WRITE, line_address(19'h2AAAA, 8'hAA, 5'h15)); // clean to dirty
    push_access(CMD_READ,  line_address(19'h55555, 8'h55, 5'h15));
    push_access(CMD_WRITE, line_address(19'h2AAAA, 8'h55, 5'h0A)); // write miss, clean victim
    push_access(CMD_READ,  line_address(19'h2AAAA, 8'h55, '1));
    n_directed = access_q.size();
  endtask

  // mostly accesses with one of four tags, most of them on eight hot lines, so hits and
  // both victim kinds keep coming; the rest fully random addresses
  task automatic build_random();
    logic [TAG_W-1:0]   tag_pool [4];
    logic [INDEX_W-1:0] hot_lines [8];
    logic [INDEX_W-1:0] idx;
    int                 roll;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = TAG_W'($urandom);
    tag_pool[3] = TAG_W'($urandom);
    hot_lines[0] = '0;
    hot_lines[1] = '1;
    for (int i = 2; i < 8; i++) hot_lines[i] = INDEX_W'($urandom);
    for (int i = 0; i < N_RANDOM; i++) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        push_access(1'($urandom), $urandom);
      end else begin
        if ($urandom_range(99) < 60) idx = hot_lines[$urandom_range(7)];
        else idx = INDEX_W'($urandom_range(NUM_LINES - 1));
        push_access(1'($urandom),
                    line_address(tag_pool[$urandom_range(3)], idx, OFFSET_W'($urandom)));
      end
    end
  endtask

  // percent of cycles the sender stays quiet, by position in the stream
  function automatic int sender_idle_pct(int i);
    int quarter;
    if (i < n_directed) return 0;
    quarter = (i - n_directed) * 4 / N_RANDOM;
    case (quarter)
      0: return 0;
      1: return 82;
      2: return 0;   // receiver stalls cannot happen here, so back to back again
      default: return 37;
    endcase
  endfunction

  // drive one beat per handshake; a beat stays on the ports until accepted
  task automatic run_accesses();
    int next_i;
    next_i = 0;
    while (next_i < access_q.size()) begin
      @(posedge clk);
      if (start && !busy) begin
        sb.note_access(in_command, in_address);
        next_i++;
      end
      // only change the ports when no beat is waiting on busy
      if (!start || !busy) begin
        if (next_i < access_q.size() && $urandom_range(99) >= sender_idle_pct(next_i)) begin
          start      <= 1'b1;
          in_command <= access_q[next_i].command;
          in_address <= access_q[next_i].address;
        end else begin
          start <= 1'b0;
        end
      end
    end
  endtask

  // result beats last one cycle and cannot be stalled
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_lookup(out_hit, out_eviction, out_victim_address);
  end

  initial begin
    int drain;
    sb = new();
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_command <= CMD_READ;
    in_address <= '0;
    build_directed();
    build_random();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // busy covers the clearing sweep, so beats simply wait on the handshake
    run_accesses();
    drain = 0;
    while (sb.pending() > 0 && drain < 200) begin
      @(posedge clk);
      drain++;
    end
    // keep watching for any stray result beat before the verdict
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
